// ----- hdl/highpass_energy_voice_detector_macros.svh -----
// assertion macros for the high-pass energy voice detector
// used by the modules under hdl that expect clk and rst_n in scope
`ifndef HIGHPASS_ENERGY_VOICE_DETECTOR_MACROS_SVH
`define HIGHPASS_ENERGY_VOICE_DETECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define HPVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPVD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HPVD_ASSERT(lbl, prop, msg)
`define HPVD_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/hpvd_pkg.sv -----
// shared constants and types of the high-pass energy voice detector
// no dependencies
`default_nettype none

package hpvd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_CHUNK   = 4096;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 42;
  localparam int ALPHA_W     = 16;
  localparam int THR_W       = 31;

  // filter datapath widths
  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int YW_W   = RND_W - ALPHA_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int THRP_W = THR_W + CNT_W;

  // front queue
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // register port
  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(63060);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(241592);

  // register select, taken from paddr[2]
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_THR   = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   thr;
  } cfg_t;

  typedef struct packed {
    logic             speech;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] len;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/hpvd_front.sv -----
// front queue: accepts samples and holds them until the back end takes them
// depends on hpvd_pkg and highpass_energy_voice_detector_macros.svh
`default_nettype none
`include "highpass_energy_voice_detector_macros.svh"

module hpvd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  hpvd_pkg::item_t in_item,
  output hpvd_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);

  hpvd_pkg::item_t               mem_r [hpvd_pkg::Q_DEPTH];
  logic [hpvd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [hpvd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [hpvd_pkg::QCNT_W-1:0]   cnt_r;
  logic                          wr;
  logic                          rd;

  assign full    = (cnt_r == hpvd_pkg::QCNT_W'(hpvd_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `HPVD_NEVER(a_pop_empty, q_pop && !q_valid, "back end pops an empty queue")
  `HPVD_ASSERT(a_fill, (wr && !rd) |=> (cnt_r == $past(cnt_r) + 1'b1), "fill count lost a write")

endmodule

`default_nettype wire

// ----- hdl/hpvd_back.sv -----
// back end: high-pass filter, square, accumulate and chunk decision
// depends on hpvd_pkg and highpass_energy_voice_detector_macros.svh
`default_nettype none
`include "highpass_energy_voice_detector_macros.svh"

module hpvd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hpvd_pkg::cfg_t    cfg,
  input  hpvd_pkg::item_t   q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output hpvd_pkg::result_t out_res,
  output logic              out_valid,
  input  logic              out_take
);

  localparam int SB = hpvd_pkg::SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SAT,
    S_SQ,
    S_ACC,
    S_THR,
    S_OUT
  } state_t;

  state_t                             state_r;
  logic signed [SB-1:0]               prev_out_r;
  logic signed [SB-1:0]               prev_in_r;
  logic signed [SB-1:0]               x_r;
  logic                               last_r;
  logic signed [hpvd_pkg::PROD_W-1:0] prod_r;
  logic signed [SB-1:0]               y_r;
  logic [hpvd_pkg::SQ_W-1:0]          sq_r;
  logic [hpvd_pkg::SUM_W-1:0]         sum_r;
  logic [hpvd_pkg::CNT_W-1:0]         cnt_r;
  logic [hpvd_pkg::THRP_W-1:0]        thrp_r;
  hpvd_pkg::result_t                  res_r;
  logic                               res_valid_r;

  logic signed [SB-1:0]               x_in;
  logic signed [hpvd_pkg::DIFF_W-1:0] diff;
  logic signed [hpvd_pkg::PROD_W-1:0] prod_nxt;
  logic [hpvd_pkg::RND_W-1:0]         rnd;
  logic [hpvd_pkg::YW_W-1:0]          y_wide;
  logic                               y_fits;
  logic signed [SB-1:0]               y_nxt;
  logic signed [hpvd_pkg::SQ_W-1:0]   sq_nxt;
  logic [hpvd_pkg::SUM_W:0]           sum_add;
  logic [hpvd_pkg::SUM_W-1:0]         sum_nxt;
  logic [hpvd_pkg::CNT_W-1:0]         cnt_nxt;
  logic [hpvd_pkg::THRP_W-1:0]        thrp_nxt;
  logic                               res_load;

  // d = y_prev + x - x_prev, then scaled by alpha
  assign x_in = $signed(q_item.sample);
  assign diff = {{2{prev_out_r[SB-1]}}, prev_out_r} + {{2{x_in[SB-1]}}, x_in}
              - {{2{prev_in_r[SB-1]}}, prev_in_r};
  assign prod_nxt = $signed({1'b0, cfg.alpha}) * diff;

  // round half up, then saturate to the sample range
  assign rnd    = {prod_r[hpvd_pkg::PROD_W-1], prod_r}
                + hpvd_pkg::RND_W'(1 << (hpvd_pkg::ALPHA_W - 1));
  assign y_wide = rnd[hpvd_pkg::RND_W-1:hpvd_pkg::ALPHA_W];
  assign y_fits = (&y_wide[hpvd_pkg::YW_W-1:SB-1]) || !(|y_wide[hpvd_pkg::YW_W-1:SB-1]);
  assign y_nxt  = y_fits ? $signed(y_wide[SB-1:0])
                : (y_wide[hpvd_pkg::YW_W-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                                            : $signed({1'b0, {(SB-1){1'b1}}}));

  assign sq_nxt = y_r * y_r;

  // saturating sum and sample count
  assign sum_add  = {1'b0, sum_r} + (hpvd_pkg::SUM_W + 1)'(sq_r);
  assign sum_nxt  = sum_add[hpvd_pkg::SUM_W] ? {hpvd_pkg::SUM_W{1'b1}}
                                             : sum_add[hpvd_pkg::SUM_W-1:0];
  assign cnt_nxt  = (cnt_r < hpvd_pkg::CNT_W'(hpvd_pkg::MAX_CHUNK)) ? cnt_r + 1'b1 : cnt_r;
  assign thrp_nxt = cfg.thr * cnt_r;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign res_load = (state_r == S_OUT) && (!res_valid_r || out_take);

  assign out_res   = res_r;
  assign out_valid = res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_out_r  <= '0;
      prev_in_r   <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_take) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            prod_r  <= prod_nxt;
            x_r     <= x_in;
            last_r  <= q_item.last;
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          y_r        <= y_nxt;
          prev_out_r <= y_nxt;
          prev_in_r  <= x_r;
          state_r    <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= sq_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_nxt;
          cnt_r   <= cnt_nxt;
          state_r <= last_r ? S_THR : S_IDLE;
        end
        S_THR: begin
          thrp_r  <= thrp_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_load) begin
            res_r.speech <= (hpvd_pkg::THRP_W'(sum_r) > thrp_r);
            res_r.sum    <= sum_r;
            res_r.len    <= cnt_r;
            prev_out_r   <= '0;
            prev_in_r    <= '0;
            sum_r        <= '0;
            cnt_r        <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `HPVD_NEVER(a_cnt_cap, cnt_r > hpvd_pkg::CNT_W'(hpvd_pkg::MAX_CHUNK), "sample count past cap")
  `HPVD_ASSERT(a_chunk_clear, res_load |=> (sum_r == '0 && cnt_r == '0 && res_valid_r), "chunk not cleared")
  `HPVD_ASSERT(a_res_hold, (res_valid_r && !out_take) |=> (res_valid_r && $stable(res_r)), "waiting result lost")

endmodule

`default_nettype wire

// ----- hdl/highpass_energy_voice_detector.sv -----
// top level: register port, front sample queue and back-end filter/energy engine
// depends on hpvd_pkg, hpvd_front and hpvd_back
`default_nettype none

//  channel   ports                                        beat taken when
//  --------  -------------------------------------------  -------------------------
//  input     in_sample, in_chunk_last / push, full        push && !full
//  result    out_speech_present, out_energy_sum,          pop && !empty
//            out_chunk_length / empty, pop
//  config    psel, penable, pwrite, paddr, pwdata,        psel && penable && pwrite
//            prdata, pready
//
//  in the back end a sample goes through multiply, round/saturate, square and
//  accumulate in that order; the last sample of a chunk then goes on to the
//  threshold multiply and to the compare and load of the result register
//  the front queue holds 4 samples, so push keeps going while the back end works
//  a result waits in one output register; the back end stalls on a last sample
//  only while that register is still full
//  rst_n is synchronous: registers go to their defaults, filter state, sum and
//  count clear, queue and result register empty

module highpass_energy_voice_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                push,
  output logic                                full,
  input  logic signed [hpvd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_chunk_last,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic                                out_speech_present,
  output logic [hpvd_pkg::SUM_W-1:0]          out_energy_sum,
  output logic [hpvd_pkg::CNT_W-1:0]          out_chunk_length,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hpvd_pkg::PADDR_W-1:0]        paddr,
  input  logic [hpvd_pkg::DATA_W-1:0]         pwdata,
  output logic [hpvd_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  hpvd_pkg::cfg_t    cfg_r;
  hpvd_pkg::item_t   in_item;
  hpvd_pkg::item_t   q_item;
  hpvd_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;
  logic              res_valid;
  logic              reg_wr;
  logic              reg_sel;

  // register port: zero wait states, register picked by paddr[2]
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha <= hpvd_pkg::ALPHA_RESET;
      cfg_r.thr   <= hpvd_pkg::THR_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        hpvd_pkg::REG_ALPHA: cfg_r.alpha <= pwdata[hpvd_pkg::ALPHA_W-1:0];
        hpvd_pkg::REG_THR:   cfg_r.thr   <= pwdata[hpvd_pkg::THR_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_sel)
      hpvd_pkg::REG_ALPHA: prdata = hpvd_pkg::DATA_W'(cfg_r.alpha);
      hpvd_pkg::REG_THR:   prdata = hpvd_pkg::DATA_W'(cfg_r.thr);
      default:             prdata = '0;
    endcase
  end

  assign in_item.sample = in_sample;
  assign in_item.last   = in_chunk_last;

  // front: sample queue
  hpvd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: filter, energy and decision, with the result register
  hpvd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_valid (res_valid),
    .out_take  (pop)
  );

  assign empty              = !res_valid;
  assign out_speech_present = res.speech;
  assign out_energy_sum     = res.sum;
  assign out_chunk_length   = res.len;

endmodule

`default_nettype wire
